/* design/scc_pkg.sv */
// Shared types and constants for the segment convex hull clip block.
// Used by the controller, the datapath and the top level.
package scc_pkg;

    localparam int SCC_FRAC_BITS  = 16;
    localparam int SCC_COORD_BITS = 32;

    localparam int IN_W   = 32;
    localparam int DIR_W  = 33;
    localparam int T_W    = 32;
    localparam int Q_W    = 31;
    localparam int ACC_W  = 68;
    localparam int OP_W   = 36;
    localparam int PROD_W = 72;
    localparam int DIV_W  = 98;
    localparam int LEN_W  = 35;
    localparam int RAD_W  = 70;
    localparam int REM_W  = 38;
    localparam int CNT_W  = 6;

    localparam logic OP_SEG   = 1'b0;
    localparam logic OP_PLANE = 1'b1;

    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_DEN  = 3'd1;
    localparam logic [2:0] MUL_GAP  = 3'd2;
    localparam logic [2:0] MUL_SQ   = 3'd3;
    localparam logic [2:0] MUL_PT   = 3'd4;
    localparam logic [2:0] MUL_DIST = 3'd5;

    typedef struct packed {
        logic       load_seg;
        logic       load_plane;
        logic [2:0] mul_sel;
        logic [1:0] mul_idx;
        logic       use_exit;
        logic       acc_clr;
        logic       zero_test;
        logic       div_init;
        logic       div_step;
        logic       t_update;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       out_miss;
        logic       clear_ivl;
    } scc_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_sat;
        logic missed;
    } scc_status_t;

endpackage

/* design/scc_datapath.sv */
// Datapath: segment and interval registers, shared multiplier, divider and square root.
// Depends on scc_pkg; driven by scc_controller commands.
module scc_datapath import scc_pkg::*; #(
    parameter int FRAC_BITS  = SCC_FRAC_BITS,
    parameter int COORD_BITS = SCC_COORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  scc_cmd_t               cmd,
    output scc_status_t            status,
    input  logic signed [IN_W-1:0] s_pos_x,
    input  logic signed [IN_W-1:0] s_pos_y,
    input  logic signed [IN_W-1:0] s_pos_z,
    input  logic signed [IN_W-1:0] s_end_x,
    input  logic signed [IN_W-1:0] s_end_y,
    input  logic signed [IN_W-1:0] s_end_z,
    input  logic signed [IN_W-1:0] s_norm_x,
    input  logic signed [IN_W-1:0] s_norm_y,
    input  logic signed [IN_W-1:0] s_norm_z,
    output logic signed [IN_W-1:0] m_point_x,
    output logic signed [IN_W-1:0] m_point_y,
    output logic signed [IN_W-1:0] m_point_z,
    output logic [30:0]            m_distance,
    output logic                   m_hit,
    output logic                   m_last
);

    localparam logic signed [T_W-1:0] T_ONE = T_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PROD_W-1:0] COORD_HI =
        (PROD_W'(1) <<< (COORD_BITS - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] COORD_LO = -COORD_HI - PROD_W'(1);
    localparam logic [PROD_W-1:0] DIST_MAX = PROD_W'(31'h7FFF_FFFF);

    logic signed [IN_W-1:0]   start_reg [3];
    logic signed [DIR_W-1:0]  dir_reg   [3];
    logic signed [IN_W-1:0]   norm_reg  [3];
    logic signed [DIR_W-1:0]  pa_reg    [3];
    logic signed [T_W-1:0]    t_enter_reg, t_exit_reg;
    logic                     missed_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [2:0]               tag_sel_reg;
    logic [1:0]               tag_idx_reg;
    logic                     tag_exit_reg;
    logic signed [ACC_W-1:0]  den_acc_reg, gap_acc_reg, sq_acc_reg;
    logic [DIV_W-1:0]         num_reg, dsh_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     tneg_reg, dneg_reg, sat_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [LEN_W-1:0]         root_reg;
    logic signed [IN_W-1:0]   out_pt_reg [3];
    logic [30:0]              out_dist_reg;
    logic                     out_hit_reg, out_last_reg;

    logic signed [OP_W-1:0]   op_a, op_b;
    logic signed [T_W-1:0]    t_sel;
    logic signed [ACC_W-1:0]  prod_acc;
    logic signed [PROD_W-1:0] pt_sum, pt_sat;
    logic [PROD_W-1:0]        dist_sh;
    logic [ACC_W-1:0]         den_mag, gap_mag;
    logic [DIV_W-1:0]         den_ext, num_init;
    logic                     div_ge;
    logic signed [T_W-1:0]    t_new, t_enter_next, t_exit_next;
    logic [REM_W-1:0]         rem_try, trial;

    assign t_sel = cmd.use_exit ? t_exit_reg : t_enter_reg;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            MUL_DEN: begin
                op_a = OP_W'(norm_reg[cmd.mul_idx]);
                op_b = OP_W'(dir_reg[cmd.mul_idx]);
            end
            MUL_GAP: begin
                op_a = OP_W'(norm_reg[cmd.mul_idx]);
                op_b = OP_W'(pa_reg[cmd.mul_idx]);
            end
            MUL_SQ: begin
                op_a = OP_W'(dir_reg[cmd.mul_idx]);
                op_b = OP_W'(dir_reg[cmd.mul_idx]);
            end
            MUL_PT: begin
                op_a = OP_W'(t_sel);
                op_b = OP_W'(dir_reg[cmd.mul_idx]);
            end
            MUL_DIST: begin
                op_a = OP_W'(t_sel);
                op_b = signed'(OP_W'({1'b0, root_reg}));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_acc = ACC_W'(prod_reg);
    assign pt_sum   = (prod_reg >>> FRAC_BITS) + PROD_W'(start_reg[tag_idx_reg]);
    assign pt_sat   = (pt_sum > COORD_HI) ? COORD_HI :
                      ((pt_sum < COORD_LO) ? COORD_LO : pt_sum);
    assign dist_sh  = unsigned'(prod_reg) >> FRAC_BITS;

    assign den_mag  = unsigned'(den_acc_reg[ACC_W-1] ? -den_acc_reg : den_acc_reg);
    assign gap_mag  = unsigned'(gap_acc_reg[ACC_W-1] ? -gap_acc_reg : gap_acc_reg);
    assign den_ext  = DIV_W'(den_mag);
    assign num_init = DIV_W'(gap_mag) << FRAC_BITS;
    assign div_ge   = num_reg >= dsh_reg;

    always_comb begin
        t_new        = tneg_reg ? -T_W'({1'b0, q_reg}) : T_W'({1'b0, q_reg});
        t_enter_next = t_enter_reg;
        t_exit_next  = t_exit_reg;
        if (dneg_reg) begin
            if (t_new > t_enter_reg) t_enter_next = t_new;
        end else begin
            if (t_new < t_exit_reg) t_exit_next = t_new;
        end
    end

    assign rem_try = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};

    assign status.den_zero = den_acc_reg == '0;
    assign status.div_sat  = sat_reg;
    assign status.missed   = missed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= '0;
                dir_reg[i]   <= '0;
            end
            t_enter_reg <= '0;
            t_exit_reg  <= T_ONE;
            missed_reg  <= 1'b0;
            tag_sel_reg <= MUL_NONE;
        end else begin
            tag_sel_reg <= cmd.mul_sel;
            if (cmd.load_seg) begin
                start_reg[0] <= s_pos_x;
                start_reg[1] <= s_pos_y;
                start_reg[2] <= s_pos_z;
                dir_reg[0]   <= DIR_W'(s_end_x) - DIR_W'(s_pos_x);
                dir_reg[1]   <= DIR_W'(s_end_y) - DIR_W'(s_pos_y);
                dir_reg[2]   <= DIR_W'(s_end_z) - DIR_W'(s_pos_z);
            end
            if (cmd.clear_ivl) begin
                t_enter_reg <= '0;
                t_exit_reg  <= T_ONE;
                missed_reg  <= 1'b0;
            end else if (cmd.t_update) begin
                t_enter_reg <= t_enter_next;
                t_exit_reg  <= t_exit_next;
                if (t_enter_next > t_exit_next) missed_reg <= 1'b1;
            end else if (cmd.zero_test) begin
                if (!gap_acc_reg[ACC_W-1] && gap_acc_reg != '0) missed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= op_a * op_b;
        tag_idx_reg  <= cmd.mul_idx;
        tag_exit_reg <= cmd.use_exit;
        if (cmd.load_plane) begin
            norm_reg[0] <= s_norm_x;
            norm_reg[1] <= s_norm_y;
            norm_reg[2] <= s_norm_z;
            pa_reg[0]   <= DIR_W'(s_pos_x) - DIR_W'(start_reg[0]);
            pa_reg[1]   <= DIR_W'(s_pos_y) - DIR_W'(start_reg[1]);
            pa_reg[2]   <= DIR_W'(s_pos_z) - DIR_W'(start_reg[2]);
        end
        if (cmd.acc_clr) begin
            den_acc_reg <= '0;
            gap_acc_reg <= '0;
            sq_acc_reg  <= '0;
        end else begin
            case (tag_sel_reg)
                MUL_DEN: den_acc_reg <= den_acc_reg + prod_acc;
                MUL_GAP: gap_acc_reg <= gap_acc_reg + prod_acc;
                MUL_SQ:  sq_acc_reg  <= sq_acc_reg + prod_acc;
                MUL_PT:  out_pt_reg[tag_idx_reg] <= pt_sat[IN_W-1:0];
                MUL_DIST: begin
                    out_dist_reg <= (dist_sh > DIST_MAX) ? 31'h7FFF_FFFF : dist_sh[30:0];
                    out_hit_reg  <= 1'b1;
                    out_last_reg <= tag_exit_reg;
                end
                default: ;
            endcase
        end
        if (cmd.div_init) begin
            num_reg  <= num_init;
            dsh_reg  <= den_ext << (Q_W - 1);
            sat_reg  <= num_init >= (den_ext << Q_W);
            q_reg    <= (num_init >= (den_ext << Q_W)) ? '1 : '0;
            tneg_reg <= gap_acc_reg[ACC_W-1] ^ den_acc_reg[ACC_W-1];
            dneg_reg <= den_acc_reg[ACC_W-1];
        end else if (cmd.div_step) begin
            if (div_ge) num_reg <= num_reg - dsh_reg;
            q_reg   <= {q_reg[Q_W-2:0], div_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= RAD_W'(unsigned'(sq_acc_reg));
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= rad_reg << 2;
            if (rem_try >= trial) begin
                rem_reg  <= rem_try - trial;
                root_reg <= {root_reg[LEN_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_try;
                root_reg <= {root_reg[LEN_W-2:0], 1'b0};
            end
        end
        if (cmd.out_miss) begin
            for (int i = 0; i < 3; i++) out_pt_reg[i] <= '0;
            out_dist_reg <= '0;
            out_hit_reg  <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_point_x  = out_pt_reg[0];
    assign m_point_y  = out_pt_reg[1];
    assign m_point_z  = out_pt_reg[2];
    assign m_distance = out_dist_reg;
    assign m_hit      = out_hit_reg;
    assign m_last     = out_last_reg;

endmodule

/* design/scc_controller.sv */
// Controller state machine: sequences dot products, division, square root and results.
// Depends on scc_pkg; drives scc_datapath through scc_cmd_t.
module scc_controller import scc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic        s_last_plane,
    output logic        m_valid,
    input  logic        m_ready,
    output scc_cmd_t    cmd,
    input  scc_status_t status
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DOT     = 4'd1;
    localparam logic [3:0] ST_DIVINIT = 4'd2;
    localparam logic [3:0] ST_DIV     = 4'd3;
    localparam logic [3:0] ST_UPD     = 4'd4;
    localparam logic [3:0] ST_POST    = 4'd5;
    localparam logic [3:0] ST_SQ      = 4'd6;
    localparam logic [3:0] ST_SQRTI   = 4'd7;
    localparam logic [3:0] ST_SQRT    = 4'd8;
    localparam logic [3:0] ST_PT      = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(LEN_W - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(Q_W - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             exit_reg, exit_next;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = state_reg == ST_OUT;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        exit_next    = exit_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_NONE;
        cmd.use_exit = exit_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_SEG) begin
                        cmd.load_seg  = 1'b1;
                        cmd.clear_ivl = 1'b1;
                    end else begin
                        last_next = s_last_plane;
                        if (status.missed) begin
                            state_next = ST_POST;
                        end else begin
                            cmd.load_plane = 1'b1;
                            cmd.acc_clr    = 1'b1;
                            cnt_next       = '0;
                            state_next     = ST_DOT;
                        end
                    end
                end
            end
            ST_DOT: begin
                if (cnt_reg < CNT_W'(3)) begin
                    cmd.mul_sel = MUL_DEN;
                    cmd.mul_idx = cnt_reg[1:0];
                end else if (cnt_reg < CNT_W'(6)) begin
                    cmd.mul_sel = MUL_GAP;
                    cmd.mul_idx = 2'(cnt_reg - CNT_W'(3));
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(6)) state_next = ST_DIVINIT;
            end
            ST_DIVINIT: begin
                if (status.den_zero) begin
                    cmd.zero_test = 1'b1;
                    state_next    = ST_POST;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = DIV_STEPS;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_sat) begin
                    state_next = ST_UPD;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        cnt_next   = '0;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                cmd.t_update = 1'b1;
                state_next   = ST_POST;
            end
            ST_POST: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (status.missed) begin
                    cmd.out_miss = 1'b1;
                    exit_next    = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.acc_clr = 1'b1;
                    exit_next   = 1'b0;
                    cnt_next    = '0;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ: begin
                if (cnt_reg < CNT_W'(3)) begin
                    cmd.mul_sel = MUL_SQ;
                    cmd.mul_idx = cnt_reg[1:0];
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(3)) state_next = ST_SQRTI;
            end
            ST_SQRTI: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = SQRT_STEPS;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    cnt_next   = '0;
                    state_next = ST_PT;
                end
            end
            ST_PT: begin
                if (cnt_reg < CNT_W'(3)) begin
                    cmd.mul_sel = MUL_PT;
                    cmd.mul_idx = cnt_reg[1:0];
                end else if (cnt_reg == CNT_W'(3)) begin
                    cmd.mul_sel = MUL_DIST;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(4)) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (exit_reg) begin
                        cmd.clear_ivl = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        exit_next  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_PT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            exit_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            exit_reg  <= exit_next;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= SQRT_STEPS)
        else $error("step counter out of range");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && !status.div_sat && cnt_reg == '0) |=> state_reg == ST_UPD)
        else $error("divider did not finish after last step");

    a_final_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && exit_reg) |=> s_ready)
        else $error("not idle after final result");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input open while result pending");

endmodule

/* design/segment_convex_hull_clip_top.sv */
// Segment versus convex hull clipping, Q16.16 fixed point, Cyrus-Beck interval.
// Top level: joins scc_controller and scc_datapath; depends on scc_pkg.
//
// Input channel s_*: op 0 loads a segment (start, end), op 1 brings one face
// plane (point, outward normal); last_plane on a plane closes the hull.
// Result channel m_*: a miss gives one transfer (hit 0, last 1); a hit gives
// the entry point then the exit point, each with its distance t*|d|.
// One item is in work at a time; s_ready is high only when idle.
// Segment item: loaded in idle, s_ready stays high. Plane item: the work of
// the 31-step restoring divider plus the shared multiplier for the two dot
// products; a saturating or parallel plane finishes sooner; a plane after a
// miss skips the arithmetic. On the last plane the 35-step square root of
// |d|^2 and the point/distance products run before the first result; the
// second follows the first transfer, from the point/distance products again.
// While m_valid waits on m_ready the block holds its result and accepts nothing.
// Synchronous reset clears the segment to zero and the interval to [0, 1].
module segment_convex_hull_clip_top import scc_pkg::*; #(
    parameter int FRAC_BITS  = SCC_FRAC_BITS,
    parameter int COORD_BITS = SCC_COORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic signed [IN_W-1:0] s_pos_x,
    input  logic signed [IN_W-1:0] s_pos_y,
    input  logic signed [IN_W-1:0] s_pos_z,
    input  logic signed [IN_W-1:0] s_end_x,
    input  logic signed [IN_W-1:0] s_end_y,
    input  logic signed [IN_W-1:0] s_end_z,
    input  logic signed [IN_W-1:0] s_norm_x,
    input  logic signed [IN_W-1:0] s_norm_y,
    input  logic signed [IN_W-1:0] s_norm_z,
    input  logic                   s_last_plane,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [IN_W-1:0] m_point_x,
    output logic signed [IN_W-1:0] m_point_y,
    output logic signed [IN_W-1:0] m_point_z,
    output logic [30:0]            m_distance,
    output logic                   m_hit,
    output logic                   m_last
);

    scc_cmd_t    cmd;
    scc_status_t status;

    scc_controller u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_last_plane (s_last_plane),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .status       (status)
    );

    scc_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .s_end_z    (s_end_z),
        .s_norm_x   (s_norm_x),
        .s_norm_y   (s_norm_y),
        .s_norm_z   (s_norm_z),
        .m_point_x  (m_point_x),
        .m_point_y  (m_point_y),
        .m_point_z  (m_point_z),
        .m_distance (m_distance),
        .m_hit      (m_hit),
        .m_last     (m_last)
    );

endmodule
